FILE: design/speck64_128_ctr_keystream_xor_macros.svh
// assertion helpers, clocked on clk_i, disabled in reset
`ifndef SPECK64_128_CTR_KEYSTREAM_XOR_MACROS_SVH
`define SPECK64_128_CTR_KEYSTREAM_XOR_MACROS_SVH

`define SPK_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("speck ctr assertion failed");

`define SPK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("speck ctr assertion failed");

`endif

FILE: design/spk_ctr_pkg.sv
package spk_ctr_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned BlkW  = 64;
  localparam int unsigned CntW  = 4;
  localparam int unsigned RndW  = 5;

  localparam logic [CntW-1:0] FullCnt = 4'd8;

  localparam logic [1:0] RegKeyLow   = 2'd0;
  localparam logic [1:0] RegKeyHigh  = 2'd1;
  localparam logic [1:0] RegNonce    = 2'd2;

  typedef struct packed {
    logic [WordW-1:0] x;
    logic [WordW-1:0] y;
    logic [WordW-1:0] rk;
    logic [WordW-1:0] l0;
    logic [WordW-1:0] l1;
    logic [WordW-1:0] l2;
    logic [RndW-1:0]  rnd;
    logic [BlkW-1:0]  data;
    logic [CntW-1:0]  cnt;
  } stage_t;

  function automatic logic [BlkW-1:0] byte_mask(input logic [CntW-1:0] cnt);
    logic [BlkW-1:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (cnt > CntW'(b)) m[b*8 +: 8] = 8'hff;
    end
    return m;
  endfunction

endpackage

FILE: design/spk_ctr_round_cell.sv
module spk_ctr_round_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  spk_ctr_pkg::stage_t stage_i,
  output logic                valid_o,
  output spk_ctr_pkg::stage_t stage_o
);
  import spk_ctr_pkg::*;

  logic   valid_q;
  stage_t stage_q;
  stage_t stage_d;

  logic [WordW-1:0] x_new;
  logic [WordW-1:0] l_new;

  always_comb begin
    x_new = ({stage_i.x[7:0], stage_i.x[WordW-1:8]} + stage_i.y) ^ stage_i.rk;
    l_new = ({stage_i.l0[7:0], stage_i.l0[WordW-1:8]} + stage_i.rk)
            ^ {{(WordW-RndW){1'b0}}, stage_i.rnd};
    stage_d      = stage_i;
    stage_d.x    = x_new;
    stage_d.y    = {stage_i.y[WordW-4:0], stage_i.y[WordW-1:WordW-3]} ^ x_new;
    stage_d.rk   = {stage_i.rk[WordW-4:0], stage_i.rk[WordW-1:WordW-3]} ^ l_new;
    stage_d.l0   = stage_i.l1;
    stage_d.l1   = stage_i.l2;
    stage_d.l2   = l_new;
    stage_d.rnd  = stage_i.rnd + RndW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

FILE: design/speck64_128_ctr_keystream_xor.sv
// Speck64/128 counter-mode keystream XOR, one round per cell.
// Path: an accepted word passes through the round cells, then the registered XOR output.
// Throughput: one word per cycle; a stalled output fills empty cells before the input stalls.
// Reset: valid flags, counter and key/nonce registers clear to zero; no clearing pass.
module speck64_128_ctr_keystream_xor #(
  parameter int unsigned ROUND_COUNT = 27
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] data_in_i,
  input  logic [3:0]  valid_bytes_i,
  input  logic        first_block_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] data_out_o,
  output logic [3:0]  out_bytes_o
);
  import spk_ctr_pkg::*;

  logic [BlkW-1:0]  key_low_q;
  logic [BlkW-1:0]  key_high_q;
  logic [BlkW-1:0]  nonce_q;
  logic [WordW-1:0] ctr_q;
  logic [WordW-1:0] ctr_d;
  logic [WordW-1:0] ctr_use;

  stage_t          stg [ROUND_COUNT+1];
  logic [ROUND_COUNT:0] vld;
  logic [ROUND_COUNT:0] en;

  logic            out_valid_q;
  logic [BlkW-1:0] data_out_q;
  logic [CntW-1:0] out_bytes_q;
  logic            in_acc;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      nonce_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegKeyLow:  key_low_q  <= cfg_data_i;
        RegKeyHigh: key_high_q <= cfg_data_i;
        RegNonce:   nonce_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_acc  = in_valid_i && en[0];
  assign ctr_use = first_block_i ? nonce_q[WordW-1:0] : ctr_q;
  assign ctr_d   = in_acc ? ctr_use + WordW'(1) : ctr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q <= '0;
    end else begin
      ctr_q <= ctr_d;
    end
  end

  always_comb begin
    stg[0].x    = nonce_q[BlkW-1:WordW];
    stg[0].y    = ctr_use;
    stg[0].rk   = key_low_q[WordW-1:0];
    stg[0].l0   = key_low_q[BlkW-1:WordW];
    stg[0].l1   = key_high_q[WordW-1:0];
    stg[0].l2   = key_high_q[BlkW-1:WordW];
    stg[0].rnd  = '0;
    stg[0].data = data_in_i;
    stg[0].cnt  = (valid_bytes_i > FullCnt) ? FullCnt : valid_bytes_i;
  end

  assign vld[0] = in_valid_i;
  assign en[ROUND_COUNT] = !out_valid_q || !out_stall_i;

  for (genvar k = 0; k < ROUND_COUNT; k++) begin : g_cell
    assign en[k] = !vld[k+1] || en[k+1];
    spk_ctr_round_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en[k]),
      .valid_i (vld[k]),
      .stage_i (stg[k]),
      .valid_o (vld[k+1]),
      .stage_o (stg[k+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en[ROUND_COUNT]) begin
      out_valid_q <= vld[ROUND_COUNT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ROUND_COUNT] && vld[ROUND_COUNT]) begin
      data_out_q  <= (stg[ROUND_COUNT].data ^ {stg[ROUND_COUNT].x, stg[ROUND_COUNT].y})
                     & byte_mask(stg[ROUND_COUNT].cnt);
      out_bytes_q <= stg[ROUND_COUNT].cnt;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = out_valid_q;
  assign data_out_o  = data_out_q;
  assign out_bytes_o = out_bytes_q;

`include "speck64_128_ctr_keystream_xor_macros.svh"

  `SPK_ASSERT_SAME(a_cnt_sat, out_valid_o, out_bytes_o <= FullCnt)
  `SPK_ASSERT_SAME(a_tail_zero, out_valid_o, (data_out_o & ~byte_mask(out_bytes_o)) == '0)
  `SPK_ASSERT_SAME(a_round_cnt, vld[ROUND_COUNT], stg[ROUND_COUNT].rnd == RndW'(ROUND_COUNT))
  `SPK_ASSERT_NEXT(a_ctr_reload, in_acc && first_block_i, ctr_q == $past(nonce_q[31:0]) + 32'd1)

endmodule
